[design/tep_pkg.sv]
`default_nettype none

package tep_pkg;

  // fixed widths of the ports and of the arithmetic
  localparam int POS_W      = 33;
  localparam int RAD_W      = 32;
  localparam int Q_W        = 31;
  localparam int WIDE_W     = 2 * RAD_W;
  localparam int ROOT_W     = RAD_W;
  localparam int SQ_REM_W   = ROOT_W + 2;
  localparam int HORNER_N   = 5;
  localparam int SQRT_CELLS = ROOT_W;
  localparam int DIV_CELLS  = RAD_W;
  localparam int CFG_AW     = 4;

  // register indexes
  localparam logic [1:0] REG_RADIUS_X = 2'd0;
  localparam logic [1:0] REG_RADIUS_Y = 2'd1;
  localparam logic [1:0] REG_RADIUS_Z = 2'd2;

  typedef logic [Q_W-1:0]   q30_t;
  typedef logic [RAD_W-1:0] radius_t;

  localparam q30_t Q30_ONE = 31'h4000_0000;

  // odd taylor terms of sin(pi/2 * t), highest first
  localparam q30_t SIN_K [0:HORNER_N] = '{
    31'd3864, 31'd172272, 31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
  };

  // sine lane result: q30 magnitude and sign
  typedef struct packed {
    logic neg;
    q30_t mag;
  } trig_t;

  // square root cell state
  typedef struct packed {
    logic [WIDE_W-1:0]   rad;
    logic [SQ_REM_W-1:0] rem;
    logic [ROOT_W-1:0]   root;
  } sqrt_t;

  // divider cell state
  typedef struct packed {
    logic [RAD_W-1:0] low;
    logic [RAD_W-1:0] rem;
    logic [RAD_W-1:0] quo;
    logic [RAD_W-1:0] dvs;
  } div_t;

endpackage

`default_nettype wire

[design/tep_if.sv]
`default_nettype none

interface tep_in_if #(parameter int ANGLE_BITS = 16) ();
  logic                         valid;
  logic                         ready;
  logic [ANGLE_BITS-1:0]        longitude;
  logic signed [ANGLE_BITS-1:0] latitude;

  modport source (output valid, output longitude, output latitude, input ready);
  modport sink (input valid, input longitude, input latitude, output ready);
endinterface

interface tep_out_if ();
  logic               valid;
  logic               ready;
  logic signed [32:0] pos_x;
  logic signed [32:0] pos_y;
  logic signed [32:0] pos_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

`default_nettype wire

[design/tep_sine.sv]
`default_nettype none

module tep_sine import tep_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [ANGLE_BITS-1:0] angle,
  output trig_t                 res
);

  localparam int QS   = ANGLE_BITS - 2;
  localparam int PAD  = 32 - ANGLE_BITS;
  localparam int LAST = HORNER_N + 1;

  q30_t  t_r   [0:LAST];
  logic  neg_r [0:LAST];
  q30_t  t2_r  [1:LAST-1];
  q30_t  p_r   [2:LAST];
  q30_t  p_nxt [2:LAST];
  q30_t  t_raw;
  q30_t  t_in;
  q30_t  m_nxt;
  logic [2*Q_W-1:0] sq;
  logic [2*Q_W-1:0] fin;
  logic [2*Q_W-1:0] prod [2:LAST];
  trig_t res_r;

  // quarter fraction, mirrored in odd quadrants
  always_comb begin
    t_raw = q30_t'({angle[QS-1:0], {PAD{1'b0}}});
    t_in  = angle[QS] ? (Q30_ONE - t_raw) : t_raw;
  end

  // horner steps, one multiply per stage
  always_comb begin
    sq       = (2*Q_W)'(t_r[0]) * (2*Q_W)'(t_r[0]);
    prod[2]  = (2*Q_W)'(t2_r[1]) * (2*Q_W)'(SIN_K[0]);
    p_nxt[2] = SIN_K[1] - prod[2][60:30];
    for (int k = 3; k <= LAST; k++) begin
      prod[k]  = (2*Q_W)'(t2_r[k-1]) * (2*Q_W)'(p_r[k-1]);
      p_nxt[k] = SIN_K[k-1] - prod[k][60:30];
    end
    fin   = (2*Q_W)'(t_r[LAST]) * (2*Q_W)'(p_r[LAST]);
    m_nxt = fin[60:30];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r[0]   <= t_in;
      neg_r[0] <= angle[QS+1];
      for (int k = 1; k <= LAST; k++) begin
        t_r[k]   <= t_r[k-1];
        neg_r[k] <= neg_r[k-1];
      end
      t2_r[1] <= sq[60:30];
      for (int k = 2; k <= LAST - 1; k++) begin
        t2_r[k] <= t2_r[k-1];
      end
      for (int k = 2; k <= LAST; k++) begin
        p_r[k] <= p_nxt[k];
      end
      res_r.mag <= m_nxt;
      res_r.neg <= neg_r[LAST] && (m_nxt != '0);
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

[design/tep_sqrt_cell.sv]
`default_nettype none

module tep_sqrt_cell import tep_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              en,
  input  sqrt_t             din,
  input  logic [SIDE_W-1:0] side_in,
  output sqrt_t             dout,
  output logic [SIDE_W-1:0] side_out
);

  sqrt_t             d_r;
  sqrt_t             d_nxt;
  logic [SIDE_W-1:0] side_r;
  logic [SQ_REM_W:0] r4;
  logic [SQ_REM_W:0] trial;
  logic [SQ_REM_W:0] diff;
  logic              ge;

  // one root bit: bring down two radicand bits, try 4*root+1
  always_comb begin
    r4         = {din.rem[SQ_REM_W-2:0], din.rad[WIDE_W-1:WIDE_W-2]};
    trial      = {1'b0, din.root, 2'b01};
    ge         = (r4 >= trial);
    diff       = r4 - trial;
    d_nxt.rad  = {din.rad[WIDE_W-3:0], 2'b00};
    d_nxt.rem  = ge ? diff[SQ_REM_W-1:0] : r4[SQ_REM_W-1:0];
    d_nxt.root = {din.root[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= d_nxt;
      side_r <= side_in;
    end
  end

  assign dout     = d_r;
  assign side_out = side_r;

endmodule

`default_nettype wire

[design/tep_div_cell.sv]
`default_nettype none

module tep_div_cell import tep_pkg::*; (
  input  logic clk,
  input  logic en,
  input  div_t din,
  output div_t dout
);

  div_t           d_r;
  div_t           d_nxt;
  logic [RAD_W:0] r2;
  logic [RAD_W:0] diff;
  logic           ge;

  // one quotient bit, restoring
  always_comb begin
    r2        = {din.rem, din.low[RAD_W-1]};
    ge        = (r2 >= {1'b0, din.dvs});
    diff      = r2 - {1'b0, din.dvs};
    d_nxt.rem = ge ? diff[RAD_W-1:0] : r2[RAD_W-1:0];
    d_nxt.low = {din.low[RAD_W-2:0], 1'b0};
    d_nxt.quo = {din.quo[RAD_W-2:0], ge};
    d_nxt.dvs = din.dvs;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign dout = d_r;

endmodule

`default_nettype wire

[design/triaxial_ellipsoid_point.sv]
`default_nettype none

// Triaxial ellipsoid surface point. Each transaction on in_ch carries a
// longitude and a latitude as binary angles (a full circle is 2^ANGLE_BITS);
// each transaction on out_ch carries the matching point (pos_x, pos_y, pos_z)
// on the ellipsoid with semi-axes radius_x/y/z, signed Q16.16 in 33 bits.
// Radii sit in APB registers at byte addresses 0x0, 0x4 and 0x8, reset to
// 1.0; a write of zero is dropped and the old radius stays. Write them only
// while no transaction is in flight. The block takes one point per clock
// while the pipeline is not stopped; its length is set by two rows of 32
// cells: the square root cells (one root bit each) and the divider cells
// (one quotient bit each), behind 15 stages of sine, product and scaling
// logic, with two numerator stages between the rows and the output register
// at the end. The pipeline keeps moving while a finished point waits in the
// output register as long as its last stage is empty; it stops only when a
// second finished point is behind.

module triaxial_ellipsoid_point import tep_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  tep_in_if.sink            in_ch,
  tep_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [RAD_W-1:0]  cfg_pwdata,
  output logic [RAD_W-1:0]  cfg_prdata,
  output logic              cfg_pready
);

  localparam int SQ_START  = 15;
  localparam int DIV_START = SQ_START + SQRT_CELLS + 2;
  localparam int LAST_ST   = DIV_START + DIV_CELLS - 1;
  localparam int SIDE_W    = 3 + 3 * Q_W;
  localparam int PROD_W    = RAD_W + Q_W;
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam radius_t RADIUS_ONE = radius_t'(1) << FRAC_BITS;

  // ---------------------------------------------------------------- config
  radius_t    rad_r [0:2];
  logic       cfg_wr;
  logic [1:0] cfg_idx;

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < 3; j++) begin
        rad_r[j] <= RADIUS_ONE;
      end
    end else if (cfg_wr && (cfg_pwdata != '0)) begin
      // zero radius is ignored
      case (cfg_idx)
        REG_RADIUS_X: rad_r[0] <= cfg_pwdata;
        REG_RADIUS_Y: rad_r[1] <= cfg_pwdata;
        REG_RADIUS_Z: rad_r[2] <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_RADIUS_X: cfg_prdata = rad_r[0];
      REG_RADIUS_Y: cfg_prdata = rad_r[1];
      REG_RADIUS_Z: cfg_prdata = rad_r[2];
      default:      cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------- flow control
  logic v_r [0:LAST_ST];
  logic adv;
  logic in_fire;
  logic out_valid_r;

  // advance unless a finished point is stuck behind the output register
  assign adv          = !v_r[LAST_ST] || !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && adv;
  assign in_ch.ready  = adv;
  assign out_ch.valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= LAST_ST; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (adv) begin
      v_r[0] <= in_fire;
      for (int i = 1; i <= LAST_ST; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && v_r[LAST_ST]) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // ----------------------------------------------------- stages 0..7: sines
  logic [ANGLE_BITS-1:0] lon;
  logic [ANGLE_BITS-1:0] lat;
  trig_t sa, ca, sb, cb;

  assign lon = in_ch.longitude;
  assign lat = in_ch.latitude;

  tep_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_lon (
    .clk(clk), .en(adv), .angle(lon), .res(sa)
  );
  tep_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_lon (
    .clk(clk), .en(adv), .angle(lon + QUARTER), .res(ca)
  );
  tep_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_lat (
    .clk(clk), .en(adv), .angle(lat), .res(sb)
  );
  tep_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_lat (
    .clk(clk), .en(adv), .angle(lat + QUARTER), .res(cb)
  );

  // ------------------------------------------------ stages 8..14: scaling
  logic [2*Q_W-1:0]  uprod, wprod;
  q30_t              u8_r, w8_r, sb8_r;
  logic [2:0]        sgn8_r, sgn9_r, sgn10_r, sgn11_r, sgn12_r, sgn13_r, sgn14_r;
  logic [PROD_W-1:0] a9_r [0:2];
  logic [PROD_W-1:0] a10_r [0:2];
  logic [PROD_W-1:0] a11_r [0:2];
  logic [PROD_W-1:0] mx_nxt;
  logic [PROD_W-1:0] mx_r;
  logic [PROD_W-1:0] shifted [0:2];
  logic [6:0]        blen;
  logic [5:0]        sh_nxt;
  logic [5:0]        sh_r;
  q30_t              ap12_r [0:2];
  q30_t              ap13_r [0:2];
  q30_t              ap14_r [0:2];
  logic [2*Q_W-1:0]  sq13_r [0:2];
  logic [WIDE_W-1:0] sum14_r;

  always_comb begin
    // q30 products, rounded half up
    uprod  = (2*Q_W)'(ca.mag) * (2*Q_W)'(cb.mag) + ((2*Q_W)'(1) << 29);
    wprod  = (2*Q_W)'(sa.mag) * (2*Q_W)'(cb.mag) + ((2*Q_W)'(1) << 29);
    mx_nxt = a9_r[0];
    if (a9_r[1] > mx_nxt) mx_nxt = a9_r[1];
    if (a9_r[2] > mx_nxt) mx_nxt = a9_r[2];
    // smallest shift that brings the largest term below 2^31
    blen = '0;
    for (int i = 0; i < PROD_W; i++) begin
      if (mx_r[i]) blen = 7'(i + 1);
    end
    sh_nxt = (blen > 7'd31) ? 6'(blen - 7'd31) : 6'd0;
    for (int j = 0; j < 3; j++) begin
      shifted[j] = a11_r[j] >> sh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u8_r    <= uprod[60:30];
      w8_r    <= wprod[60:30];
      sb8_r   <= sb.mag;
      sgn8_r  <= {ca.neg ^ cb.neg, sa.neg ^ cb.neg, sb.neg};
      a9_r[0] <= PROD_W'(rad_r[0]) * PROD_W'(u8_r);
      a9_r[1] <= PROD_W'(rad_r[1]) * PROD_W'(w8_r);
      a9_r[2] <= PROD_W'(rad_r[2]) * PROD_W'(sb8_r);
      sgn9_r  <= sgn8_r;
      mx_r    <= mx_nxt;
      sgn10_r <= sgn9_r;
      sh_r    <= sh_nxt;
      sgn11_r <= sgn10_r;
      sgn12_r <= sgn11_r;
      sgn13_r <= sgn12_r;
      sgn14_r <= sgn13_r;
      for (int j = 0; j < 3; j++) begin
        a10_r[j]  <= a9_r[j];
        a11_r[j]  <= a10_r[j];
        ap12_r[j] <= shifted[j][Q_W-1:0];
        sq13_r[j] <= (2*Q_W)'(ap12_r[j]) * (2*Q_W)'(ap12_r[j]);
        ap13_r[j] <= ap12_r[j];
        ap14_r[j] <= ap13_r[j];
      end
      sum14_r <= WIDE_W'(sq13_r[0]) + WIDE_W'(sq13_r[1]) + WIDE_W'(sq13_r[2]);
    end
  end

  // ------------------------------------------- stages 15..46: square root
  sqrt_t             sq_c  [0:SQRT_CELLS];
  logic [SIDE_W-1:0] sqs_c [0:SQRT_CELLS];

  assign sq_c[0]  = '{rad: sum14_r, rem: '0, root: '0};
  assign sqs_c[0] = {sgn14_r, ap14_r[0], ap14_r[1], ap14_r[2]};

  for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
    tep_sqrt_cell #(.SIDE_W(SIDE_W)) u_cell (
      .clk(clk), .en(adv),
      .din(sq_c[k]), .side_in(sqs_c[k]),
      .dout(sq_c[k+1]), .side_out(sqs_c[k+1])
    );
  end

  // ------------------------------------- stages 47..48: numerators r*a+n/2
  q30_t              ap_end [0:2];
  logic [PROD_W-1:0] prod47_r [0:2];
  logic [ROOT_W-1:0] n47_r, n48_r;
  logic [2:0]        sgn47_r, sgn48_r;
  logic [WIDE_W-1:0] num48_r [0:2];

  assign ap_end[0] = sqs_c[SQRT_CELLS][3*Q_W-1:2*Q_W];
  assign ap_end[1] = sqs_c[SQRT_CELLS][2*Q_W-1:Q_W];
  assign ap_end[2] = sqs_c[SQRT_CELLS][Q_W-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      n47_r   <= sq_c[SQRT_CELLS].root;
      sgn47_r <= sqs_c[SQRT_CELLS][SIDE_W-1:SIDE_W-3];
      n48_r   <= n47_r;
      sgn48_r <= sgn47_r;
      for (int j = 0; j < 3; j++) begin
        prod47_r[j] <= PROD_W'(rad_r[j]) * PROD_W'(ap_end[j]);
        num48_r[j]  <= WIDE_W'(prod47_r[j]) + WIDE_W'(n47_r >> 1);
      end
    end
  end

  // ----------------------------------------------- stages 49..80: dividers
  div_t       dv_c [0:2][0:DIV_CELLS];
  logic [3:0] sd_r [0:DIV_CELLS-1];   // {norm nonzero, signs x y z}

  for (genvar j = 0; j < 3; j++) begin : g_axis
    assign dv_c[j][0] = '{low: num48_r[j][RAD_W-1:0], rem: num48_r[j][WIDE_W-1:RAD_W],
                          quo: '0, dvs: n48_r};
    for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
      tep_div_cell u_cell (
        .clk(clk), .en(adv), .din(dv_c[j][k]), .dout(dv_c[j][k+1])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_r[0] <= {n48_r != '0, sgn48_r};
      for (int k = 1; k < DIV_CELLS; k++) begin
        sd_r[k] <= sd_r[k-1];
      end
    end
  end

  // ------------------------------------------------------ output register
  logic [POS_W-1:0] pos_nxt [0:2];
  logic [POS_W-1:0] pos_r   [0:2];
  logic [3:0]       sd_end;
  logic [RAD_W-1:0] quo;

  assign sd_end = sd_r[DIV_CELLS-1];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      quo = dv_c[j][DIV_CELLS].quo;
      // zero norm gives the origin
      if (!sd_end[3]) begin
        pos_nxt[j] = '0;
      end else if (sd_end[2-j]) begin
        pos_nxt[j] = '0 - {1'b0, quo};
      end else begin
        pos_nxt[j] = {1'b0, quo};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v_r[LAST_ST]) begin
      for (int j = 0; j < 3; j++) begin
        pos_r[j] <= pos_nxt[j];
      end
    end
  end

  assign out_ch.pos_x = pos_r[0];
  assign out_ch.pos_y = pos_r[1];
  assign out_ch.pos_z = pos_r[2];

endmodule

`default_nettype wire

[design/tep_check.sv]
`default_nettype none

module tep_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [32:0] pos_x,
  input logic        cfg_psel,
  input logic        cfg_pwrite,
  input logic [3:0]  cfg_paddr,
  input logic [31:0] cfg_prdata,
  input logic        cfg_pready
);

  // a held result keeps its pos_x value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pos_x))
    else $error("result changed while stalled");

  // an empty output register never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a radius never reads back as zero
  a_radius_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && !cfg_pwrite && (cfg_paddr[3:2] != 2'd3) |-> cfg_prdata != '0)
    else $error("radius reads zero");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("pready low");

endmodule

bind triaxial_ellipsoid_point tep_check u_tep_check (
  .clk(clk), .rst_n(rst_n),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .pos_x(out_ch.pos_x),
  .cfg_psel(cfg_psel), .cfg_pwrite(cfg_pwrite), .cfg_paddr(cfg_paddr),
  .cfg_prdata(cfg_prdata), .cfg_pready(cfg_pready)
);

`default_nettype wire
